### sv/scan_line_gap_interpolator_defines.svh
// assertion macros for the scan line gap interpolator
`ifndef SCAN_LINE_GAP_INTERPOLATOR_DEFINES_SVH
`define SCAN_LINE_GAP_INTERPOLATOR_DEFINES_SVH

// same-cycle implication
`define SLGI_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("slgi assertion failed");

// next-cycle implication
`define SLGI_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("slgi assertion failed");

`endif

### sv/slgi_pkg.sv
// ---------------------------------------------------------------------------
// slgi_pkg
// shared constants and types of the scan line gap interpolator
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package slgi_pkg;
   localparam int MAX_SPAN_DEF   = 5;
   localparam int COORD_BITS_DEF = 20;
   localparam int CFG_BITS       = 16;
   localparam int CSR_INDEX_BITS = 2;

   localparam logic [CFG_BITS-1:0] MAX_FILL_ERROR_RST     = 16'd1000;
   localparam logic [CFG_BITS-1:0] BASE_ERROR_RST         = 16'd50;
   localparam logic [CFG_BITS-1:0] RANGE_ERROR_FACTOR_RST = 16'd655;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      REG_MAX_FILL_ERROR     = 2'd0,
      REG_BASE_ERROR         = 2'd1,
      REG_RANGE_ERROR_FACTOR = 2'd2
   } csr_index_type;

   typedef struct packed {
      logic [CFG_BITS-1:0] max_fill_error;
      logic [CFG_BITS-1:0] base_error;
      logic [CFG_BITS-1:0] range_error_factor;
   } cfg_type;

   typedef enum logic [1:0] {
      BK_IDLE,
      BK_MUL,
      BK_DIV,
      BK_EMIT
   } back_state_type;

   // multiplier sequence of the distance check
   typedef enum logic [4:0] {
      ST_K,
      ST_DX,
      ST_KK,
      ST_DY,
      ST_DZ,
      ST_MFE,
      ST_BE,
      ST_AX,
      ST_AY,
      ST_PX,
      ST_PY,
      ST_GAP,
      ST_LL,
      ST_LH,
      ST_HL,
      ST_HH,
      ST_DRAIN,
      ST_DECIDE
   } step_type;
endpackage
`default_nettype wire

### sv/slgi_channels.sv
// ---------------------------------------------------------------------------
// slgi channels
// valid/ready channel interfaces for points, results and register writes
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
interface slgi_req_if #(parameter int COORD_BITS = slgi_pkg::COORD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] point_x;
   logic signed [COORD_BITS-1:0] point_y;
   logic signed [COORD_BITS-1:0] point_z;
   logic                         point_valid;
   logic                         row_end;
   modport source (output valid, point_x, point_y, point_z, point_valid, row_end,
                   input ready);
   modport sink   (input valid, point_x, point_y, point_z, point_valid, row_end,
                   output ready);
endinterface

interface slgi_rsp_if #(parameter int COORD_BITS = slgi_pkg::COORD_BITS_DEF);
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] out_x;
   logic signed [COORD_BITS-1:0] out_y;
   logic signed [COORD_BITS-1:0] out_z;
   logic                         out_valid;
   logic                         out_filled;
   logic                         out_row_end;
   logic                         last_of_run;
   modport source (output valid, out_x, out_y, out_z, out_valid, out_filled,
                   out_row_end, last_of_run, input ready);
   modport sink   (input valid, out_x, out_y, out_z, out_valid, out_filled,
                   out_row_end, last_of_run, output ready);
endinterface

interface slgi_csr_if;
   logic                                valid;
   logic                                ready;
   logic [slgi_pkg::CSR_INDEX_BITS-1:0] index;
   logic [slgi_pkg::CFG_BITS-1:0]       data;
   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

### sv/slgi_fifo.sv
// ---------------------------------------------------------------------------
// slgi_fifo
// small job queue between the classifier and the output sequencer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module slgi_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 2
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             push_valid,
   input  wire logic [WIDTH-1:0] push_data,
   output logic                  push_ready,
   output logic                  pop_valid,
   output logic [WIDTH-1:0]      pop_data,
   input  wire logic             pop_ready
);
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNTW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [AW-1:0]    wr_ff, wr_in, rd_ff, rd_in;
   logic [CNTW-1:0]  cnt_ff, cnt_in;
   logic             do_push, do_pop;

   assign push_ready = (cnt_ff != CNTW'(DEPTH));
   assign pop_valid  = (cnt_ff != '0);
   assign pop_data   = mem_ff[rd_ff];
   assign do_push    = push_valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_in  = wr_ff;
      rd_in  = rd_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (do_pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + CNTW'(1);
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - CNTW'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ff] <= push_data;
      end
   end
endmodule
`default_nettype wire

### sv/slgi_front.sv
// ---------------------------------------------------------------------------
// slgi_front
// row tracking: holds gap points and turns every point it does not hold into an output job
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module slgi_front #(
   parameter int  MAX_SPAN   = slgi_pkg::MAX_SPAN_DEF,
   parameter int  COORD_BITS = slgi_pkg::COORD_BITS_DEF,
   localparam int PW = 3 * COORD_BITS,
   localparam int HN = MAX_SPAN - 1,
   localparam int NW = $clog2(MAX_SPAN),
   localparam int JW = 2 * PW + HN * PW + NW + 3
) (
   input  wire logic        clock,
   input  wire logic        reset,
   slgi_req_if.sink         req,
   output logic             push_valid,
   output logic [JW-1:0]    push_data,
   input  wire logic        push_ready
);
   localparam int HIW = (HN > 1) ? $clog2(HN) : 1;

   logic [PW-1:0]    anchor_ff, anchor_in;
   logic             present_ff, present_in;
   logic [PW-1:0]    held_ff [HN];
   logic [NW-1:0]    count_ff, count_in;
   logic             too_long_ff, too_long_in;
   logic [PW-1:0]    pt;
   logic [HN*PW-1:0] held_flat;
   logic             accept, hold, check, pass_valid;
   logic [NW-1:0]    job_n;

   assign req.ready = push_ready;
   assign accept    = req.valid && push_ready;
   assign pt        = {req.point_z, req.point_y, req.point_x};

   always_comb begin
      for (int i = 0; i < HN; i++) begin
         held_flat[i*PW +: PW] = held_ff[i];
      end
   end

   always_comb begin
      anchor_in   = anchor_ff;
      present_in  = present_ff;
      count_in    = count_ff;
      too_long_in = too_long_ff;
      hold        = 1'b0;
      check       = 1'b0;
      pass_valid  = 1'b0;
      job_n       = '0;
      if (req.point_valid) begin
         check       = (count_ff != '0);
         job_n       = count_ff;
         pass_valid  = 1'b1;
         anchor_in   = pt;
         present_in  = 1'b1;
         count_in    = '0;
         too_long_in = 1'b0;
      end else if (!present_ff || too_long_ff) begin
         job_n = '0;
      end else if ((count_ff < NW'(HN)) && !req.row_end) begin
         hold     = 1'b1;
         count_in = count_ff + NW'(1);
      end else begin
         // gap too long or open at row end: flush what is held
         job_n       = count_ff;
         count_in    = '0;
         too_long_in = 1'b1;
      end
      if (req.row_end) begin
         present_in  = 1'b0;
         count_in    = '0;
         too_long_in = 1'b0;
      end
   end

   assign push_valid = accept && !hold;
   assign push_data  = {req.row_end, pass_valid, check, job_n, held_flat, anchor_ff, pt};

   always_ff @(posedge clock) begin
      if (reset) begin
         anchor_ff   <= '0;
         present_ff  <= 1'b0;
         count_ff    <= '0;
         too_long_ff <= 1'b0;
      end else if (accept) begin
         anchor_ff   <= anchor_in;
         present_ff  <= present_in;
         count_ff    <= count_in;
         too_long_ff <= too_long_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && hold) begin
         held_ff[count_ff[HIW-1:0]] <= pt;
      end
   end
endmodule
`default_nettype wire

### sv/slgi_div.sv
// ---------------------------------------------------------------------------
// slgi_div
// restoring divider, one quotient bit per cycle
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module slgi_div #(
   parameter int NUM_BITS = 21,
   parameter int DEN_BITS = 6
) (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                start,
   input  wire logic [NUM_BITS-1:0] num,
   input  wire logic [DEN_BITS-1:0] den,
   output logic                     done,
   output logic [NUM_BITS-1:0]      quo,
   output logic [DEN_BITS-1:0]      rem
);
   localparam int CNTW = $clog2(NUM_BITS + 1);

   logic [NUM_BITS-1:0] num_ff, quo_ff;
   logic [DEN_BITS-1:0] den_ff, rem_ff;
   logic [CNTW-1:0]     cnt_ff;
   logic                busy_ff, done_ff;
   logic [DEN_BITS:0]   rem_sh;
   logic                qbit;

   assign rem_sh = {rem_ff, num_ff[NUM_BITS-1]};
   assign qbit   = (rem_sh >= {1'b0, den_ff});
   assign done   = done_ff;
   assign quo    = quo_ff;
   assign rem    = rem_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         done_ff <= 1'b0;
         if (start) begin
            busy_ff <= 1'b1;
            cnt_ff  <= CNTW'(NUM_BITS);
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff - CNTW'(1);
            if (cnt_ff == CNTW'(1)) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (start) begin
         num_ff <= num;
         den_ff <= den;
         rem_ff <= '0;
         quo_ff <= '0;
      end else if (busy_ff) begin
         num_ff <= {num_ff[NUM_BITS-2:0], 1'b0};
         quo_ff <= {quo_ff[NUM_BITS-2:0], qbit};
         rem_ff <= qbit ? DEN_BITS'(rem_sh - {1'b0, den_ff}) : rem_sh[DEN_BITS-1:0];
      end
   end
endmodule
`default_nettype wire

### sv/slgi_back.sv
// ---------------------------------------------------------------------------
// slgi_back
// gap check, interpolation and result sequencing with an output register
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module slgi_back #(
   parameter int  MAX_SPAN   = slgi_pkg::MAX_SPAN_DEF,
   parameter int  COORD_BITS = slgi_pkg::COORD_BITS_DEF,
   localparam int PW = 3 * COORD_BITS,
   localparam int HN = MAX_SPAN - 1,
   localparam int NW = $clog2(MAX_SPAN),
   localparam int JW = 2 * PW + HN * PW + NW + 3
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire slgi_pkg::cfg_type cfg,
   input  wire logic             pop_valid,
   input  wire logic [JW-1:0]    pop_data,
   output logic                  pop_ready,
   slgi_rsp_if.source            rsp
);
   localparam int CB    = COORD_BITS;
   localparam int HIW   = (HN > 1) ? $clog2(HN) : 1;
   localparam int CW    = $clog2(MAX_SPAN + 1);
   localparam int KH    = slgi_pkg::CFG_BITS + CW;
   localparam int RH    = CB + 1;
   localparam int MW    = (RH > KH) ? RH : KH;
   localparam int DW    = 2 * CB + 2;
   localparam int R2W   = 2 * CB + 1;
   localparam int BIGW  = 2 * KH + R2W;
   localparam int TW    = DW + 32;
   localparam int CMPW  = (BIGW > TW) ? BIGW : TW;
   localparam int OFF_H = 2 * PW;
   localparam int OFF_N = OFF_H + HN * PW;

   slgi_pkg::back_state_type state_ff, state_in;
   slgi_pkg::step_type       step_ff, tag_ff;

   // job fields
   logic signed [CB-1:0] pc_ff [3];
   logic signed [CB-1:0] ac_ff [3];
   logic [CB-1:0]        d_ff [3];
   logic                 dir_ff [3];
   logic [CB-1:0]        ax_ff, ay_ff, px_ff, py_ff;
   logic [HN*PW-1:0]     held_ff;
   logic [NW-1:0]        n_ff, e_ff;
   logic                 pv_ff, rend_ff, fill_ff;

   logic signed [CB-1:0] pop_p [3];
   logic signed [CB-1:0] pop_a [3];
   logic signed [CB:0]   pop_d [3];
   logic [CB-1:0]        pop_abs [3];
   logic                 pop_dir [3];
   logic [CB-1:0]        pop_pax, pop_pay, pop_aax, pop_aay;
   logic [PW-1:0]        held_a [HN];

   // distance check datapath
   logic [MW-1:0]     mul_a, mul_b;
   logic [2*MW-1:0]   prod_in, prod_ff;
   logic [KH-1:0]     k_ff;
   logic [2*KH-1:0]   k2_ff;
   logic [DW-1:0]     d2_ff;
   logic [31:0]       lim_m_ff, lim_b_ff;
   logic [R2W-1:0]    r2a_ff, r2b_ff, r2;
   logic [BIGW-1:0]   big_ff, prod_big;
   logic [CW-1:0]     cnt;
   logic              fill_now;

   // interpolation
   logic [1:0]        cix_ff;
   logic              div_go_ff, div_done;
   logic [CB:0]       div_quo;
   logic [CW:0]       div_rem;
   logic [CB:0]       qs_ff [3];
   logic [CW:0]       rs_ff [3];
   logic [CB:0]       q_ff [3];
   logic [CW:0]       r_ff [3];
   logic [CB:0]       q_nx [3];
   logic [CW:0]       r_nx [3];

   // output register
   logic                 rsp_valid_ff, rsp_free;
   logic signed [CB-1:0] o_ff [3];
   logic                 ov_ff, of_ff, ore_ff, olast_ff;
   logic signed [CB-1:0] ip [3];
   logic [PW-1:0]        hsel;

   logic load_job, mul_run, go_div, div_take, emit, emit_last;

   function automatic logic [CB-1:0] abs_c(input logic signed [CB-1:0] v);
      logic signed [CB:0] w;
      w = {v[CB-1], v};
      abs_c = w[CB] ? CB'(-w) : w[CB-1:0];
   endfunction

   always_comb begin
      for (int c = 0; c < 3; c++) begin
         pop_p[c]   = pop_data[c*CB +: CB];
         pop_a[c]   = pop_data[PW + c*CB +: CB];
         pop_d[c]   = {pop_p[c][CB-1], pop_p[c]} - {pop_a[c][CB-1], pop_a[c]};
         pop_dir[c] = !pop_d[c][CB];
         pop_abs[c] = pop_d[c][CB] ? CB'(-pop_d[c]) : pop_d[c][CB-1:0];
      end
      pop_pax = abs_c(pop_p[0]);
      pop_pay = abs_c(pop_p[1]);
      pop_aax = abs_c(pop_a[0]);
      pop_aay = abs_c(pop_a[1]);
      for (int i = 0; i < HN; i++) begin
         held_a[i] = held_ff[i*PW +: PW];
      end
   end

   assign cnt      = CW'(n_ff) + CW'(1);
   assign r2       = (r2a_ff > r2b_ff) ? r2a_ff : r2b_ff;
   assign rsp_free = !rsp_valid_ff || rsp.ready;

   // one shared multiplier, registered product
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (step_ff)
         slgi_pkg::ST_K: begin
            mul_a = MW'(cfg.range_error_factor);
            mul_b = MW'(cnt);
         end
         slgi_pkg::ST_DX: begin
            mul_a = MW'(d_ff[0]);
            mul_b = MW'(d_ff[0]);
         end
         slgi_pkg::ST_KK: begin
            mul_a = MW'(k_ff);
            mul_b = MW'(k_ff);
         end
         slgi_pkg::ST_DY: begin
            mul_a = MW'(d_ff[1]);
            mul_b = MW'(d_ff[1]);
         end
         slgi_pkg::ST_DZ: begin
            mul_a = MW'(d_ff[2]);
            mul_b = MW'(d_ff[2]);
         end
         slgi_pkg::ST_MFE: begin
            mul_a = MW'(cfg.max_fill_error);
            mul_b = MW'(cfg.max_fill_error);
         end
         slgi_pkg::ST_BE: begin
            mul_a = MW'(cfg.base_error);
            mul_b = MW'(cfg.base_error);
         end
         slgi_pkg::ST_AX: begin
            mul_a = MW'(ax_ff);
            mul_b = MW'(ax_ff);
         end
         slgi_pkg::ST_AY: begin
            mul_a = MW'(ay_ff);
            mul_b = MW'(ay_ff);
         end
         slgi_pkg::ST_PX: begin
            mul_a = MW'(px_ff);
            mul_b = MW'(px_ff);
         end
         slgi_pkg::ST_PY: begin
            mul_a = MW'(py_ff);
            mul_b = MW'(py_ff);
         end
         slgi_pkg::ST_LL: begin
            mul_a = MW'(k2_ff[KH-1:0]);
            mul_b = MW'(r2[RH-1:0]);
         end
         slgi_pkg::ST_LH: begin
            mul_a = MW'(k2_ff[KH-1:0]);
            mul_b = MW'(r2[R2W-1:RH]);
         end
         slgi_pkg::ST_HL: begin
            mul_a = MW'(k2_ff[2*KH-1:KH]);
            mul_b = MW'(r2[RH-1:0]);
         end
         slgi_pkg::ST_HH: begin
            mul_a = MW'(k2_ff[2*KH-1:KH]);
            mul_b = MW'(r2[R2W-1:RH]);
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   assign prod_in  = (2*MW)'(mul_a) * (2*MW)'(mul_b);
   assign prod_big = BIGW'(prod_ff);

   // d < max error, and d < 2*base or d*65536 < factor*cnt*r, all squared
   assign fill_now = (CMPW'(d2_ff) < CMPW'(lim_m_ff))
                  && ((CMPW'(d2_ff) < CMPW'({lim_b_ff, 2'b00}))
                   || (CMPW'({d2_ff, 32'h0}) < CMPW'(big_ff)));

   always_comb begin
      state_in  = state_ff;
      pop_ready = 1'b0;
      load_job  = 1'b0;
      mul_run   = 1'b0;
      go_div    = 1'b0;
      div_take  = 1'b0;
      emit      = 1'b0;
      emit_last = 1'b0;
      case (state_ff)
         slgi_pkg::BK_IDLE: begin
            pop_ready = 1'b1;
            if (pop_valid) begin
               load_job = 1'b1;
               state_in = pop_data[OFF_N+NW] ? slgi_pkg::BK_MUL : slgi_pkg::BK_EMIT;
            end
         end
         slgi_pkg::BK_MUL: begin
            mul_run = 1'b1;
            if (step_ff == slgi_pkg::ST_DECIDE) begin
               go_div   = fill_now;
               state_in = fill_now ? slgi_pkg::BK_DIV : slgi_pkg::BK_EMIT;
            end
         end
         slgi_pkg::BK_DIV: begin
            if (div_done) begin
               div_take = 1'b1;
               if (cix_ff == 2'd2) begin
                  state_in = slgi_pkg::BK_EMIT;
               end else begin
                  go_div = 1'b1;
               end
            end
         end
         slgi_pkg::BK_EMIT: begin
            if (rsp_free) begin
               emit = 1'b1;
               if (e_ff == n_ff) begin
                  emit_last = 1'b1;
                  state_in  = slgi_pkg::BK_IDLE;
               end
            end
         end
         default: state_in = slgi_pkg::BK_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= slgi_pkg::BK_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   slgi_div #(
      .NUM_BITS(CB + 1),
      .DEN_BITS(CW + 1)
   ) u_div (
      .clock(clock),
      .reset(reset),
      .start(div_go_ff),
      .num  ({d_ff[cix_ff], 1'b0}),
      .den  ({cnt, 1'b0}),
      .done (div_done),
      .quo  (div_quo),
      .rem  (div_rem)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         div_go_ff <= 1'b0;
      end else begin
         div_go_ff <= go_div;
      end
   end

   // job capture and check datapath
   always_ff @(posedge clock) begin
      if (load_job) begin
         for (int c = 0; c < 3; c++) begin
            pc_ff[c]  <= pop_p[c];
            ac_ff[c]  <= pop_a[c];
            d_ff[c]   <= pop_abs[c];
            dir_ff[c] <= pop_dir[c];
         end
         px_ff   <= pop_pax;
         py_ff   <= pop_pay;
         ax_ff   <= pop_aax;
         ay_ff   <= pop_aay;
         held_ff <= pop_data[OFF_H +: HN*PW];
         n_ff    <= pop_data[OFF_N +: NW];
         pv_ff   <= pop_data[OFF_N+NW+1];
         rend_ff <= pop_data[OFF_N+NW+2];
         fill_ff <= 1'b0;
         e_ff    <= '0;
         step_ff <= slgi_pkg::ST_K;
         tag_ff  <= slgi_pkg::ST_DECIDE;
      end
      if (mul_run) begin
         prod_ff <= prod_in;
         tag_ff  <= step_ff;
         if (step_ff != slgi_pkg::ST_DECIDE) begin
            step_ff <= slgi_pkg::step_type'(step_ff + 5'd1);
         end
         case (tag_ff)
            slgi_pkg::ST_K:   k_ff     <= prod_ff[KH-1:0];
            slgi_pkg::ST_DX:  d2_ff    <= DW'(prod_ff);
            slgi_pkg::ST_KK:  k2_ff    <= prod_ff[2*KH-1:0];
            slgi_pkg::ST_DY:  d2_ff    <= d2_ff + DW'(prod_ff);
            slgi_pkg::ST_DZ:  d2_ff    <= d2_ff + DW'(prod_ff);
            slgi_pkg::ST_MFE: lim_m_ff <= prod_ff[31:0];
            slgi_pkg::ST_BE:  lim_b_ff <= prod_ff[31:0];
            slgi_pkg::ST_AX:  r2a_ff   <= R2W'(prod_ff);
            slgi_pkg::ST_AY:  r2a_ff   <= r2a_ff + R2W'(prod_ff);
            slgi_pkg::ST_PX:  r2b_ff   <= R2W'(prod_ff);
            slgi_pkg::ST_PY:  r2b_ff   <= r2b_ff + R2W'(prod_ff);
            slgi_pkg::ST_LL:  big_ff   <= prod_big;
            slgi_pkg::ST_LH:  big_ff   <= big_ff + (prod_big << RH);
            slgi_pkg::ST_HL:  big_ff   <= big_ff + (prod_big << KH);
            slgi_pkg::ST_HH:  big_ff   <= big_ff + (prod_big << (KH + RH));
            default: ;
         endcase
         if (step_ff == slgi_pkg::ST_DECIDE) begin
            fill_ff <= fill_now;
            cix_ff  <= 2'd0;
            for (int c = 0; c < 3; c++) begin
               q_ff[c] <= '0;
               r_ff[c] <= (CW+1)'(cnt);
            end
         end
      end
      if (div_take) begin
         qs_ff[cix_ff] <= div_quo;
         rs_ff[cix_ff] <= div_rem;
         cix_ff        <= cix_ff + 2'd1;
      end
      if (emit && !emit_last) begin
         e_ff <= e_ff + NW'(1);
         for (int c = 0; c < 3; c++) begin
            q_ff[c] <= q_nx[c];
            r_ff[c] <= r_nx[c];
         end
      end
   end

   always_comb begin
      hsel = held_a[e_ff[HIW-1:0]];
      for (int c = 0; c < 3; c++) begin
         // step each rounded quotient by 2D/(2cnt) with carry of the remainder
         if ((CW+2)'(r_ff[c]) + (CW+2)'(rs_ff[c]) >= (CW+2)'({cnt, 1'b0})) begin
            q_nx[c] = q_ff[c] + qs_ff[c] + (CB+1)'(1);
            r_nx[c] = (CW+1)'((CW+2)'(r_ff[c]) + (CW+2)'(rs_ff[c])
                              - (CW+2)'({cnt, 1'b0}));
         end else begin
            q_nx[c] = q_ff[c] + qs_ff[c];
            r_nx[c] = (CW+1)'((CW+2)'(r_ff[c]) + (CW+2)'(rs_ff[c]));
         end
         ip[c] = dir_ff[c] ? CB'({{2{ac_ff[c][CB-1]}}, ac_ff[c]} + {1'b0, q_nx[c]})
                           : CB'({{2{ac_ff[c][CB-1]}}, ac_ff[c]} - {1'b0, q_nx[c]});
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (emit) begin
         if (emit_last) begin
            for (int c = 0; c < 3; c++) begin
               o_ff[c] <= pc_ff[c];
            end
            ov_ff    <= pv_ff;
            of_ff    <= 1'b0;
            ore_ff   <= rend_ff;
            olast_ff <= 1'b1;
         end else begin
            for (int c = 0; c < 3; c++) begin
               o_ff[c] <= fill_ff ? ip[c] : hsel[c*CB +: CB];
            end
            ov_ff    <= fill_ff;
            of_ff    <= fill_ff;
            ore_ff   <= 1'b0;
            olast_ff <= 1'b0;
         end
      end
   end

   assign rsp.valid       = rsp_valid_ff;
   assign rsp.out_x       = o_ff[0];
   assign rsp.out_y       = o_ff[1];
   assign rsp.out_z       = o_ff[2];
   assign rsp.out_valid   = ov_ff;
   assign rsp.out_filled  = of_ff;
   assign rsp.out_row_end = ore_ff;
   assign rsp.last_of_run = olast_ff;
endmodule
`default_nettype wire

### sv/scan_line_gap_interpolator.sv
// Scan line gap interpolator. Points of one scan row come in on req_chan in
// order; short runs of invalid points after a valid point are held back and,
// when the next valid point closes the gap and the endpoint distance is small
// enough, replaced by linearly interpolated points marked valid and filled.
// Every point leaves on rsp_chan; last_of_run marks the final result caused
// by one input transaction. Throughput: the input side takes one point per
// cycle into a two-entry job queue while the queue has room; the output
// sequencer takes each job in its idle state and then spends one cycle per
// result while the output register is free; a point that closes a gap adds
// a run of the shared multiplier sequence, and three runs of the bit-serial
// divider, one per coordinate, when the gap gets filled. Held points cost no
// sequencer time until their gap is resolved. Registers must be written over
// csr_chan only while the block is idle; the block does not enforce this.
// ---------------------------------------------------------------------------
// scan_line_gap_interpolator
// top level: register file, classifier, job queue and output sequencer
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module scan_line_gap_interpolator #(
   parameter int MAX_SPAN   = slgi_pkg::MAX_SPAN_DEF,
   parameter int COORD_BITS = slgi_pkg::COORD_BITS_DEF
) (
   input  wire logic clock,
   input  wire logic reset,
   slgi_req_if.sink   req_chan,
   slgi_rsp_if.source rsp_chan,
   slgi_csr_if.sink   csr_chan
);
   // job: point, anchor, held points, held count, check, valid, row end
   localparam int PW = 3 * COORD_BITS;
   localparam int HN = MAX_SPAN - 1;
   localparam int NW = $clog2(MAX_SPAN);
   localparam int JW = 2 * PW + HN * PW + NW + 3;

   slgi_pkg::cfg_type cfg_ff;
   logic              push_valid, push_ready, pop_valid, pop_ready;
   logic [JW-1:0]     push_data, pop_data;

   // register writes are always taken; unknown indexes are dropped
   assign csr_chan.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.max_fill_error     <= slgi_pkg::MAX_FILL_ERROR_RST;
         cfg_ff.base_error         <= slgi_pkg::BASE_ERROR_RST;
         cfg_ff.range_error_factor <= slgi_pkg::RANGE_ERROR_FACTOR_RST;
      end else if (csr_chan.valid) begin
         case (slgi_pkg::csr_index_type'(csr_chan.index))
            slgi_pkg::REG_MAX_FILL_ERROR:     cfg_ff.max_fill_error     <= csr_chan.data;
            slgi_pkg::REG_BASE_ERROR:         cfg_ff.base_error         <= csr_chan.data;
            slgi_pkg::REG_RANGE_ERROR_FACTOR: cfg_ff.range_error_factor <= csr_chan.data;
            default: ;
         endcase
      end
   end

   // classifier: tracks the row and the open gap
   slgi_front #(
      .MAX_SPAN  (MAX_SPAN),
      .COORD_BITS(COORD_BITS)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req       (req_chan),
      .push_valid(push_valid),
      .push_data (push_data),
      .push_ready(push_ready)
   );

   // short queue so the classifier keeps taking points while results drain
   slgi_fifo #(
      .WIDTH(JW),
      .DEPTH(2)
   ) u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push_valid(push_valid),
      .push_data (push_data),
      .push_ready(push_ready),
      .pop_valid (pop_valid),
      .pop_data  (pop_data),
      .pop_ready (pop_ready)
   );

   // sequencer: distance check, interpolation and output register
   slgi_back #(
      .MAX_SPAN  (MAX_SPAN),
      .COORD_BITS(COORD_BITS)
   ) u_back (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg_ff),
      .pop_valid(pop_valid),
      .pop_data (pop_data),
      .pop_ready(pop_ready),
      .rsp      (rsp_chan)
   );
endmodule
`default_nettype wire

### sv/slgi_checker.sv
// ---------------------------------------------------------------------------
// slgi_checker
// port-level checks on the result channel
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "scan_line_gap_interpolator_defines.svh"
module slgi_checker #(
   parameter int COORD_BITS = slgi_pkg::COORD_BITS_DEF
) (
   input wire logic                  clock,
   input wire logic                  reset,
   input wire logic                  rsp_valid,
   input wire logic                  rsp_ready,
   input wire logic [COORD_BITS-1:0] rsp_x,
   input wire logic                  rsp_out_valid,
   input wire logic                  rsp_out_filled,
   input wire logic                  rsp_out_row_end,
   input wire logic                  rsp_last
);
   `SLGI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_x))
   `SLGI_ASSERT_NOW(a_filled_valid, clock, reset, rsp_valid && rsp_out_filled, rsp_out_valid)
   `SLGI_ASSERT_NOW(a_filled_mid, clock, reset, rsp_valid && rsp_out_filled, !rsp_out_row_end && !rsp_last)
   `SLGI_ASSERT_NOW(a_row_end_last, clock, reset, rsp_valid && rsp_out_row_end, rsp_last)
endmodule

bind scan_line_gap_interpolator slgi_checker #(
   .COORD_BITS(COORD_BITS)
) u_slgi_checker (
   .clock          (clock),
   .reset          (reset),
   .rsp_valid      (rsp_chan.valid),
   .rsp_ready      (rsp_chan.ready),
   .rsp_x          (rsp_chan.out_x),
   .rsp_out_valid  (rsp_chan.out_valid),
   .rsp_out_filled (rsp_chan.out_filled),
   .rsp_out_row_end(rsp_chan.out_row_end),
   .rsp_last       (rsp_chan.last_of_run)
);
`default_nettype wire

### dv/tb_scan_line_gap_interpolator.sv
// ---------------------------------------------------------------------------
// tb_scan_line_gap_interpolator
// self-checking bench: directed and random scan rows with gap filling,
// register settings between phases, random idling and back pressure
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

typedef struct {
   logic signed [19:0] x;
   logic signed [19:0] y;
   logic signed [19:0] z;
   logic               pvalid;
   logic               filled;
   logic               rend;
   logic               last;
} scan_point_type;

class gap_fill_scoreboard;
   // configuration copy
   longint unsigned max_err, base_err, factor;
   // row state
   longint anchor[3];
   bit     have_anchor;
   longint held[4][3];
   int     held_n;
   bit     too_long;
   scan_point_type pending[$];
   int     mismatches;

   function new();
      max_err = 1000; base_err = 50; factor = 655;
      have_anchor = 0; held_n = 0; too_long = 0; mismatches = 0;
      foreach (anchor[i]) anchor[i] = 0;
   endfunction

   function void set_reg(int idx, longint unsigned v);
      if (idx == slgi_pkg::REG_MAX_FILL_ERROR) max_err = v & 16'hffff;
      else if (idx == slgi_pkg::REG_BASE_ERROR) base_err = v & 16'hffff;
      else if (idx == slgi_pkg::REG_RANGE_ERROR_FACTOR) factor = v & 16'hffff;
   endfunction

   function void push(longint x, longint y, longint z, bit v, bit f, bit re);
      scan_point_type p;
      p.x = x[19:0]; p.y = y[19:0]; p.z = z[19:0];
      p.pvalid = v; p.filled = f; p.rend = re; p.last = 0;
      pending.push_back(p);
   endfunction

   // exact squared-integer distance test
   function bit close_enough(longint p[3], int cnt);
      logic [127:0] d2, r2a, r2b, r2, k;
      longint d;
      d2 = 0;
      for (int c = 0; c < 3; c++) begin
         d = anchor[c] - p[c];
         if (d < 0) d = -d;
         d2 += 128'(d) * 128'(d);
      end
      if (!(d2 < 128'(max_err) * 128'(max_err))) return 0;
      if (d2 < 128'(4) * 128'(base_err) * 128'(base_err)) return 1;
      r2a = 128'(anchor[0] * anchor[0]) + 128'(anchor[1] * anchor[1]);
      r2b = 128'(p[0] * p[0]) + 128'(p[1] * p[1]);
      r2 = (r2a > r2b) ? r2a : r2b;
      k = 128'(factor) * 128'(cnt);
      return (d2 << 32) < k * k * r2;
   endfunction

   function longint lerp(longint a, longint b, int k, int cnt);
      longint d, q;
      d = (b >= a) ? b - a : a - b;
      q = (d * k * 2 + cnt) / (2 * cnt);
      return (b >= a) ? a + q : a - q;
   endfunction

   // note an accepted input transaction, queue what it causes
   function void note_point(longint x, longint y, longint z, bit v, bit re);
      longint p[3];
      int n0;
      n0 = pending.size();
      p[0] = x; p[1] = y; p[2] = z;
      if (v) begin
         if (held_n > 0) begin
            if (close_enough(p, held_n + 1)) begin
               for (int i = 0; i < held_n; i++)
                  push(lerp(anchor[0], x, i + 1, held_n + 1),
                       lerp(anchor[1], y, i + 1, held_n + 1),
                       lerp(anchor[2], z, i + 1, held_n + 1), 1, 1, 0);
            end else begin
               for (int i = 0; i < held_n; i++)
                  push(held[i][0], held[i][1], held[i][2], 0, 0, 0);
            end
         end
         push(x, y, z, 1, 0, re);
         anchor = p;
         have_anchor = 1; held_n = 0; too_long = 0;
      end else if (!have_anchor || too_long) begin
         push(x, y, z, 0, 0, re);
      end else if (held_n < 4 && !re) begin
         held[held_n] = p;
         held_n++;
      end else begin
         for (int i = 0; i < held_n; i++)
            push(held[i][0], held[i][1], held[i][2], 0, 0, 0);
         push(x, y, z, 0, 0, re);
         held_n = 0; too_long = 1;
      end
      if (re) begin
         have_anchor = 0; held_n = 0; too_long = 0;
      end
      if (pending.size() > n0) pending[pending.size() - 1].last = 1;
   endfunction

   // compare one result transaction with the oldest expectation
   function void check_point(scan_point_type a);
      scan_point_type e;
      if (pending.size() == 0) begin
         mismatches++;
         if (mismatches <= 10) $display("unexpected result x=%0d", a.x);
         return;
      end
      e = pending.pop_front();
      if (a.x !== e.x || a.y !== e.y || a.z !== e.z || a.pvalid !== e.pvalid ||
          a.filled !== e.filled || a.rend !== e.rend || a.last !== e.last) begin
         mismatches++;
         if (mismatches <= 10)
            $display("mismatch exp %0d %0d %0d v%0b f%0b r%0b l%0b got %0d %0d %0d v%0b f%0b r%0b l%0b",
                     e.x, e.y, e.z, e.pvalid, e.filled, e.rend, e.last,
                     a.x, a.y, a.z, a.pvalid, a.filled, a.rend, a.last);
      end
   endfunction
endclass

module tb_scan_line_gap_interpolator;
   logic clock = 0;
   logic reset = 1;

   slgi_req_if req_chan ();
   slgi_rsp_if rsp_chan ();
   slgi_csr_if csr_chan ();

   scan_line_gap_interpolator i_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan.sink),
      .rsp_chan (rsp_chan.source),
      .csr_chan (csr_chan.sink)
   );

   gap_fill_scoreboard gap_sb = new();

   // receiver hold-off control
   bit rsp_hold_long = 0;
   bit rsp_idle_ok  = 1;
   int idle_cycles  = 0;
   int rsp_stall_len = 300;

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   // result side: sample at rising edge, idle at random
   initial begin
      int wait_n;
      rsp_chan.ready = 0;
      forever begin
         @(negedge clock);
         if (rsp_hold_long) begin
            rsp_chan.ready <= 0;
            // long stall counted in cycles here
            repeat (rsp_stall_len) @(negedge clock);
            rsp_hold_long = 0;
         end
         wait_n = rsp_idle_ok ? $urandom_range(0, 7) : 0;
         if (wait_n > 0) begin
            rsp_chan.ready <= 0;
            repeat (wait_n - 1) @(negedge clock);
            @(negedge clock);
         end
         rsp_chan.ready <= 1;
         do @(posedge clock); while (!rsp_chan.valid);
      end
   end

   // scoreboard hook on every accepted result transaction
   always @(posedge clock) begin
      scan_point_type a;
      if (!reset && rsp_chan.valid && rsp_chan.ready) begin
         a.x = rsp_chan.out_x; a.y = rsp_chan.out_y; a.z = rsp_chan.out_z;
         a.pvalid = rsp_chan.out_valid; a.filled = rsp_chan.out_filled;
         a.rend = rsp_chan.out_row_end; a.last = rsp_chan.last_of_run;
         gap_sb.check_point(a);
      end
   end

   // watchdog: cycles with no transaction anywhere
   always @(posedge clock) begin
      if ((req_chan.valid && req_chan.ready) || (rsp_chan.valid && rsp_chan.ready) ||
          (csr_chan.valid && csr_chan.ready) || reset)
         idle_cycles <= 0;
      else
         idle_cycles <= idle_cycles + 1;
      if (idle_cycles > 5000) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   bit sender_idles = 1;

   // send one point, idling at random first
   task automatic send_point(logic signed [19:0] x, y, z, bit v, bit re);
      int gap_n;
      gap_n = sender_idles ? $urandom_range(0, 7) : 0;
      if (gap_n > 0) begin
         req_chan.valid <= 0;
         repeat (gap_n) @(negedge clock);
      end
      req_chan.valid <= 1;
      req_chan.point_x <= x; req_chan.point_y <= y; req_chan.point_z <= z;
      req_chan.point_valid <= v; req_chan.row_end <= re;
      do @(posedge clock); while (!req_chan.ready);
      gap_sb.note_point(x, y, z, v, re);
      @(negedge clock);
   endtask

   task automatic drain_results();
      req_chan.valid <= 0;
      while (gap_sb.pending.size() > 0) @(negedge clock);
      // block may still be busy on a held point with no result
      repeat (200) @(negedge clock);
   endtask

   task automatic write_reg(slgi_pkg::csr_index_type idx, logic [15:0] v);
      csr_chan.valid <= 1;
      csr_chan.index <= idx;
      csr_chan.data <= v;
      do @(posedge clock); while (!csr_chan.ready);
      gap_sb.set_reg(idx, v);
      @(negedge clock);
      csr_chan.valid <= 0;
      @(negedge clock);
   endtask

   // valid point with a small random offset from a base
   function automatic logic signed [19:0] near(int base, int spread);
      return 20'(base + $signed($urandom_range(0, 2 * spread)) - spread);
   endfunction

   // one row shaped to hit gaps of every length
   task automatic random_row(int bx, int by, int spread);
      int len, gap;
      len = $urandom_range(3, 12);
      for (int i = 0; i < len; i++) begin
         gap = $urandom_range(0, 9);
         if (gap < 4) begin
            for (int g = 0; g < $urandom_range(1, 6); g++)
               send_point($urandom, $urandom, $urandom, 0, 0);
         end
         send_point(near(bx + 40 * i, spread), near(by, spread), near(0, spread), 1,
                    (i == len - 1) && ($urandom_range(0, 3) != 0));
      end
      if ($urandom_range(0, 2) == 0) begin
         send_point($urandom, $urandom, $urandom, 0, 0);
         send_point($urandom, $urandom, $urandom, 0, 1);
      end
   endtask

   initial begin
      req_chan.valid = 0;
      req_chan.point_x = 0; req_chan.point_y = 0; req_chan.point_z = 0;
      req_chan.point_valid = 0; req_chan.row_end = 0;
      csr_chan.valid = 0; csr_chan.index = slgi_pkg::REG_MAX_FILL_ERROR; csr_chan.data = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 0;

      // directed: gap at row start, extremes, filled gaps, long gap, open at row end
      send_point(20'sh80000, 20'sh7ffff, 0, 0, 0);
      send_point(20'sh7ffff, 20'sh80000, 20'sh7ffff, 1, 0);
      send_point(0, 0, 0, 0, 0);
      send_point(20'sh7ffff, 20'sh80000, 20'sh7ffe, 1, 0);
      send_point(1, 2, 3, 0, 0);
      send_point(-5, 9, 1, 0, 0);
      send_point(20'sh7ffff - 3, 20'sh80000 + 3, 20'sh7ffe, 1, 0);
      for (int i = 0; i < 6; i++) send_point(-i, i, 7, 0, 0);
      send_point(100, 100, 100, 1, 0);
      send_point(7, 7, 7, 0, 0);
      send_point(8, 8, 8, 0, 1);
      send_point(1000, 0, 0, 1, 0);
      for (int i = 0; i < 4; i++) send_point(0, 0, 0, 0, 0);
      send_point(1003, -1, 0, 1, 1);
      send_point(0, 0, 0, 0, 1);
      drain_results();

      // zero limit, then all-ones
      write_reg(slgi_pkg::REG_MAX_FILL_ERROR, 16'h0000);
      write_reg(slgi_pkg::REG_BASE_ERROR, 16'h0000);
      write_reg(slgi_pkg::REG_RANGE_ERROR_FACTOR, 16'h0000);
      random_row(0, 0, 20);
      drain_results();
      write_reg(slgi_pkg::REG_MAX_FILL_ERROR, 16'hffff);
      write_reg(slgi_pkg::REG_BASE_ERROR, 16'hffff);
      write_reg(slgi_pkg::REG_RANGE_ERROR_FACTOR, 16'hffff);
      random_row(-300000, 400000, 2000);
      drain_results();

      // range term decides: small base error, large cap
      write_reg(slgi_pkg::REG_BASE_ERROR, 16'd3);
      write_reg(slgi_pkg::REG_RANGE_ERROR_FACTOR, 16'd655);
      // long receiver stall while the sender keeps offering
      rsp_hold_long = 1;
      sender_idles = 0;
      random_row(20000, 5000, 300);
      sender_idles = 1;
      req_chan.valid <= 0;
      while (gap_sb.pending.size() > 0) @(negedge clock);

      for (int r = 0; r < 9; r++) begin
         if (r == 5) begin
            drain_results();
            write_reg(slgi_pkg::REG_MAX_FILL_ERROR, 16'(1000));
            write_reg(slgi_pkg::REG_BASE_ERROR, 16'(50));
            write_reg(slgi_pkg::REG_RANGE_ERROR_FACTOR, 16'($urandom_range(0, 65535)));
         end
         if (r == 6) rsp_idle_ok = 0;
         if (r == 8) rsp_idle_ok = 1;
         random_row($signed($urandom_range(0, 400000)) - 200000,
                    $signed($urandom_range(0, 400000)) - 200000,
                    $urandom_range(1, 3) == 1 ? 5000 : 400);
      end

      req_chan.valid <= 0;
      while (gap_sb.pending.size() > 0) @(negedge clock);
      repeat (200) @(negedge clock);
      if (gap_sb.mismatches == 0 && gap_sb.pending.size() == 0)
         $display("[ OK ] regression clean");
      else
         $display("[FAIL] regression broken");
      $finish;
   end
endmodule
`default_nettype wire
